// ===== src/bgb_pkg.sv =====
// Shared types and constants for the bitmap glyph blitter.
// Used by bgb_front, bgb_queue, bgb_back and bitmap_glyph_blitter.
package bgb_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int ADDR_BITS      = 24;
  localparam int COLOR_BITS     = 8;
  localparam int GLYPH_BITS     = 8;
  localparam int BYTE_BITS      = 8;
  localparam int COL_BITS       = $clog2(BYTE_BITS);
  localparam int SPAN_BITS      = COL_BITS + 1;
  localparam int QUEUE_DEPTH    = 4;
  localparam int QPTR_BITS      = $clog2(QUEUE_DEPTH);
  localparam int CFG_IDX_BITS   = 1;

  localparam int BUF_WIDTH_RST  = 320;
  localparam int BUF_HEIGHT_RST = 200;

  localparam logic [BYTE_BITS-1:0] MASK_ODD      = 8'hAA;
  localparam logic [BYTE_BITS-1:0] MASK_EVEN     = 8'h55;
  localparam logic [BYTE_BITS-1:0] MASK_ALL      = 8'hFF;
  localparam logic [BYTE_BITS-1:0] BIT_LEFT      = 8'h80;
  localparam logic [COL_BITS-1:0]  BYTE_LAST_COL = 3'd7;

  typedef enum logic {
    CMD_BEGIN = 1'b0,
    CMD_DATA  = 1'b1
  } cmd_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_BUF_WIDTH  = 1'b0,
    REG_BUF_HEIGHT = 1'b1
  } reg_idx_t;

  // One data byte after clipping and dithering, ready to expand
  typedef struct packed {
    logic [BYTE_BITS-1:0]  bits;
    logic [ADDR_BITS-1:0]  base;
    logic [COLOR_BITS-1:0] color;
  } entry_t;

endpackage

// ===== src/bitmap_glyph_blitter.sv =====
// Bitmap glyph blitter: 1-bpp glyph bytes in, byte-per-pixel writes out.
// A data byte's pixels pass through the queue and then the expander register before they show.
// Throughput: one input beat per cycle while the 4-entry queue has room; one pixel
// per cycle out while pop is high, so a byte with n painted pixels gives n result writes.
// Reset: synchronous, rst_n low; width 320 and height 200, glyph state and queue cleared.
module bitmap_glyph_blitter #(
  parameter int COORD_BITS = bgb_pkg::COORD_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             push,
  output logic                             full,
  input  logic                             in_cmd,
  input  logic [bgb_pkg::GLYPH_BITS-1:0]   in_glyph_width,
  input  logic [bgb_pkg::GLYPH_BITS-1:0]   in_glyph_height,
  input  logic [COORD_BITS-1:0]            in_top,
  input  logic [COORD_BITS-1:0]            in_left,
  input  logic [bgb_pkg::COLOR_BITS-1:0]   in_pen_color,
  input  logic                             in_greyed,
  input  logic [bgb_pkg::BYTE_BITS-1:0]    in_data_byte,
  output logic                             empty,
  input  logic                             pop,
  output logic [bgb_pkg::ADDR_BITS-1:0]    out_pixel_address,
  output logic [bgb_pkg::COLOR_BITS-1:0]   out_pixel_color,
  output logic                             out_last,
  input  logic                             cfg_we,
  input  logic [bgb_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [COORD_BITS-1:0]            cfg_data
);
  import bgb_pkg::*;

  logic   q_push, q_pop, q_full, q_empty;
  entry_t q_entry, q_rdata;

  bgb_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (push),
    .in_full         (full),
    .in_cmd          (in_cmd),
    .in_glyph_width  (in_glyph_width),
    .in_glyph_height (in_glyph_height),
    .in_top          (in_top),
    .in_left         (in_left),
    .in_pen_color    (in_pen_color),
    .in_greyed       (in_greyed),
    .in_data_byte    (in_data_byte),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_entry         (q_entry)
  );

  bgb_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_entry),
    .pop   (q_pop),
    .full  (q_full),
    .empty (q_empty),
    .rdata (q_rdata)
  );

  bgb_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_empty           (q_empty),
    .q_rdata           (q_rdata),
    .q_pop             (q_pop),
    .empty             (empty),
    .pop               (pop),
    .out_pixel_address (out_pixel_address),
    .out_pixel_color   (out_pixel_color),
    .out_last          (out_last)
  );

  a_begin_no_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !full && (cmd_t'(in_cmd) == CMD_BEGIN)) |-> !q_push)
    else $error("begin beat queued an entry");

  a_entry_painted: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> (q_entry.bits != '0) && !q_full)
    else $error("queued entry without painted pixels or into a full queue");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> empty && q_empty)
    else $error("results pending after reset");

endmodule

// ===== src/bgb_front.sv =====
// Front end: configuration registers, glyph state, clipping and byte masking.
// Depends on bgb_pkg; feeds bgb_queue with one entry per painted data byte.
module bgb_front #(
  parameter int COORD_BITS = bgb_pkg::COORD_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_push,
  output logic                                in_full,
  input  logic                                in_cmd,
  input  logic [bgb_pkg::GLYPH_BITS-1:0]      in_glyph_width,
  input  logic [bgb_pkg::GLYPH_BITS-1:0]      in_glyph_height,
  input  logic [COORD_BITS-1:0]               in_top,
  input  logic [COORD_BITS-1:0]               in_left,
  input  logic [bgb_pkg::COLOR_BITS-1:0]      in_pen_color,
  input  logic                                in_greyed,
  input  logic [bgb_pkg::BYTE_BITS-1:0]       in_data_byte,
  input  logic                                cfg_we,
  input  logic [bgb_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [COORD_BITS-1:0]               cfg_data,
  input  logic                                q_full,
  output logic                                q_push,
  output bgb_pkg::entry_t                     q_entry
);
  import bgb_pkg::*;

  logic [COORD_BITS-1:0]   buf_w_r, buf_h_r;
  logic [GLYPH_BITS-1:0]   clip_w_r, clip_w_nxt;
  logic [GLYPH_BITS-1:0]   rows_left_r, rows_left_nxt;
  logic [GLYPH_BITS-1:0]   column_r, column_nxt;
  logic [ADDR_BITS-1:0]    row_base_r, row_base_nxt;
  logic [COORD_BITS-1:0]   left_edge_r, left_edge_nxt;
  logic [COLOR_BITS-1:0]   color_r, color_nxt;
  logic                    greyed_r, greyed_nxt;
  logic                    row_odd_r, row_odd_nxt;

  logic                    accept;
  logic                    active;
  logic [COORD_BITS-1:0]   room_w, room_h;
  logic [GLYPH_BITS-1:0]   clip_w_new, clip_h_new;
  logic [2*COORD_BITS-1:0] top_prod;
  logic [GLYPH_BITS-1:0]   remain;
  logic [SPAN_BITS-1:0]    span;
  logic [BYTE_BITS-1:0]    span_mask, grey_mask, bits;
  logic [GLYPH_BITS:0]     col_sum;
  logic                    row_done;

  assign accept  = in_push && !q_full;
  assign in_full = q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_w_r <= COORD_BITS'(BUF_WIDTH_RST);
      buf_h_r <= COORD_BITS'(BUF_HEIGHT_RST);
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_BUF_WIDTH:  buf_w_r <= cfg_data;
        REG_BUF_HEIGHT: buf_h_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    room_w = (buf_w_r > in_left) ? buf_w_r - in_left : '0;
    room_h = (buf_h_r > in_top) ? buf_h_r - in_top : '0;
    clip_w_new = (COORD_BITS'(in_glyph_width) < room_w) ? in_glyph_width
                                                       : GLYPH_BITS'(room_w);
    clip_h_new = (COORD_BITS'(in_glyph_height) < room_h) ? in_glyph_height
                                                        : GLYPH_BITS'(room_h);
    top_prod = in_top * buf_w_r;
  end

  always_comb begin
    active = (rows_left_r != '0) && (clip_w_r != '0) && (column_r < clip_w_r);
    remain = clip_w_r - column_r;
    span   = (remain > GLYPH_BITS'(BYTE_BITS)) ? SPAN_BITS'(BYTE_BITS)
                                               : SPAN_BITS'(remain);
    for (int k = 0; k < BYTE_BITS; k++) begin
      span_mask[BYTE_LAST_COL - COL_BITS'(k)] = (SPAN_BITS'(k) < span);
    end
    grey_mask = greyed_r ? (row_odd_r ? MASK_ODD : MASK_EVEN) : MASK_ALL;
    bits      = in_data_byte & span_mask & grey_mask;
    col_sum   = (GLYPH_BITS + 1)'(column_r) + (GLYPH_BITS + 1)'(span);
    row_done  = col_sum >= (GLYPH_BITS + 1)'(clip_w_r);
  end

  assign q_push        = accept && (cmd_t'(in_cmd) == CMD_DATA) && active && (bits != '0);
  assign q_entry.bits  = bits;
  assign q_entry.base  = row_base_r + ADDR_BITS'(left_edge_r) + ADDR_BITS'(column_r);
  assign q_entry.color = color_r;

  always_comb begin
    clip_w_nxt    = clip_w_r;
    rows_left_nxt = rows_left_r;
    column_nxt    = column_r;
    row_base_nxt  = row_base_r;
    left_edge_nxt = left_edge_r;
    color_nxt     = color_r;
    greyed_nxt    = greyed_r;
    row_odd_nxt   = row_odd_r;
    if (accept) begin
      if (cmd_t'(in_cmd) == CMD_BEGIN) begin
        clip_w_nxt    = clip_w_new;
        rows_left_nxt = clip_h_new;
        column_nxt    = '0;
        row_base_nxt  = ADDR_BITS'(top_prod);
        left_edge_nxt = in_left;
        color_nxt     = in_pen_color;
        greyed_nxt    = in_greyed;
        row_odd_nxt   = in_top[0];
      end else if (active) begin
        if (row_done) begin
          column_nxt    = '0;
          rows_left_nxt = rows_left_r - 1'b1;
          row_base_nxt  = row_base_r + ADDR_BITS'(buf_w_r);
          row_odd_nxt   = !row_odd_r;
        end else begin
          column_nxt = GLYPH_BITS'(col_sum);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clip_w_r    <= '0;
      rows_left_r <= '0;
      column_r    <= '0;
      row_base_r  <= '0;
      left_edge_r <= '0;
      color_r     <= '0;
      greyed_r    <= 1'b0;
      row_odd_r   <= 1'b0;
    end else begin
      clip_w_r    <= clip_w_nxt;
      rows_left_r <= rows_left_nxt;
      column_r    <= column_nxt;
      row_base_r  <= row_base_nxt;
      left_edge_r <= left_edge_nxt;
      color_r     <= color_nxt;
      greyed_r    <= greyed_nxt;
      row_odd_r   <= row_odd_nxt;
    end
  end

endmodule

// ===== src/bgb_queue.sv =====
// Short entry queue between front end and pixel expander.
// Depends on bgb_pkg for the entry type and depth.
module bgb_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  bgb_pkg::entry_t wdata,
  input  logic            pop,
  output logic            full,
  output logic            empty,
  output bgb_pkg::entry_t rdata
);
  import bgb_pkg::*;

  entry_t                mem_r [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0]  head_r, tail_r;
  logic [QPTR_BITS:0]    count_r, count_nxt;
  logic                  do_push, do_pop;

  assign full    = count_r == (QPTR_BITS + 1)'(QUEUE_DEPTH);
  assign empty   = count_r == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[head_r];

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) count_nxt = count_r + 1'b1;
    else if (do_pop && !do_push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[tail_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      if (do_push) tail_r <= tail_r + 1'b1;
      if (do_pop) head_r <= head_r + 1'b1;
      count_r <= count_nxt;
    end
  end

endmodule

// ===== src/bgb_back.sv =====
// Back end: expands one queued byte into pixel writes, one per cycle while pop is high.
// Depends on bgb_pkg; drains bgb_queue and drives the result channel.
module bgb_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              q_empty,
  input  bgb_pkg::entry_t                   q_rdata,
  output logic                              q_pop,
  output logic                              empty,
  input  logic                              pop,
  output logic [bgb_pkg::ADDR_BITS-1:0]     out_pixel_address,
  output logic [bgb_pkg::COLOR_BITS-1:0]    out_pixel_color,
  output logic                              out_last
);
  import bgb_pkg::*;

  entry_t                cur_r, cur_nxt;
  logic                  valid_r, valid_nxt;
  logic [COL_BITS-1:0]   col;
  logic [BYTE_BITS-1:0]  col_bit, bits_left;
  logic                  take, load;

  // leftmost set bit, as a column offset
  always_comb begin
    logic found;
    found = 1'b0;
    col   = '0;
    for (int k = 0; k < BYTE_BITS; k++) begin
      if (!found && cur_r.bits[BYTE_LAST_COL - COL_BITS'(k)]) begin
        found = 1'b1;
        col   = COL_BITS'(k);
      end
    end
  end

  assign col_bit   = BIT_LEFT >> col;
  assign bits_left = cur_r.bits & ~col_bit;

  assign empty             = !valid_r;
  assign out_pixel_address = cur_r.base + ADDR_BITS'(col);
  assign out_pixel_color   = cur_r.color;
  assign out_last          = bits_left == '0;

  assign take  = valid_r && pop;
  assign load  = !valid_r || (take && out_last);
  assign q_pop = load && !q_empty;

  always_comb begin
    cur_nxt   = cur_r;
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = !q_empty;
      cur_nxt   = q_rdata;
    end else if (take) begin
      cur_nxt.bits = bits_left;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

endmodule

// ===== sim/bgb_checker.sv =====
`timescale 1ns / 1ps
// Pixel-write checker for bitmap_glyph_blitter: mirrors the clip and row state,
// expands every accepted data beat into the pixel writes it should cause and
// matches them in order against the result side. Depends on bgb_pkg.
module bgb_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             push,
  input  logic                             full,
  input  logic                             in_cmd,
  input  logic [bgb_pkg::GLYPH_BITS-1:0]   in_glyph_width,
  input  logic [bgb_pkg::GLYPH_BITS-1:0]   in_glyph_height,
  input  logic [bgb_pkg::COORD_BITS_DEF-1:0] in_top,
  input  logic [bgb_pkg::COORD_BITS_DEF-1:0] in_left,
  input  logic [bgb_pkg::COLOR_BITS-1:0]   in_pen_color,
  input  logic                             in_greyed,
  input  logic [bgb_pkg::BYTE_BITS-1:0]    in_data_byte,
  input  logic                             empty,
  input  logic                             pop,
  input  logic [bgb_pkg::ADDR_BITS-1:0]    out_pixel_address,
  input  logic [bgb_pkg::COLOR_BITS-1:0]   out_pixel_color,
  input  logic                             out_last,
  input  logic                             cfg_we,
  input  logic [bgb_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [bgb_pkg::COORD_BITS_DEF-1:0] cfg_data,
  output int                               mismatches,
  output int                               writes_due
);
  import bgb_pkg::*;

  typedef struct packed {
    logic [ADDR_BITS-1:0]  addr;
    logic [COLOR_BITS-1:0] color;
    logic                  last;
  } pixel_write_t;

  pixel_write_t pixel_writes_due[$];

  logic [COORD_BITS_DEF-1:0] buf_width, buf_height;
  logic [GLYPH_BITS-1:0]     clip_width, rows_left, column;
  logic [ADDR_BITS-1:0]      row_base;
  logic [COORD_BITS_DEF-1:0] left_edge;
  logic [COLOR_BITS-1:0]     held_color;
  logic                      greyed_mode, row_odd;

  function automatic int fit_span(int size, int limit, int pos);
    int room;
    room = (limit > pos) ? limit - pos : 0;
    return (size < room) ? size : room;
  endfunction

  always @(posedge clk) begin : track
    pixel_write_t got, want;
    logic [BYTE_BITS-1:0] bits;
    int span, last_k;
    if (!rst_n) begin
      buf_width   = COORD_BITS_DEF'(BUF_WIDTH_RST);
      buf_height  = COORD_BITS_DEF'(BUF_HEIGHT_RST);
      clip_width  = '0;
      rows_left   = '0;
      column      = '0;
      row_base    = '0;
      left_edge   = '0;
      held_color  = '0;
      greyed_mode = 1'b0;
      row_odd     = 1'b0;
      pixel_writes_due.delete();
    end else begin
      if (pop && !empty) begin
        got.addr  = out_pixel_address;
        got.color = out_pixel_color;
        got.last  = out_last;
        if (pixel_writes_due.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected pixel write addr %0h color %0h last %0b",
                   $time, got.addr, got.color, got.last);
        end else begin
          want = pixel_writes_due.pop_front();
          if (got.addr !== want.addr) begin
            mismatches++;
            $display("%0t: pixel_address expected %0h got %0h", $time, want.addr, got.addr);
          end
          if (got.color !== want.color) begin
            mismatches++;
            $display("%0t: pixel_color expected %0h got %0h", $time, want.color, got.color);
          end
          if (got.last !== want.last) begin
            mismatches++;
            $display("%0t: last expected %0b got %0b", $time, want.last, got.last);
          end
        end
      end

      if (cfg_we) begin
        if (cfg_index == REG_BUF_WIDTH) buf_width = cfg_data;
        else buf_height = cfg_data;
      end

      if (push && !full) begin
        if (in_cmd == CMD_BEGIN) begin
          clip_width  = GLYPH_BITS'(fit_span(in_glyph_width, buf_width, in_left));
          rows_left   = GLYPH_BITS'(fit_span(in_glyph_height, buf_height, in_top));
          column      = '0;
          row_base    = ADDR_BITS'(int'(in_top) * int'(buf_width));
          left_edge   = in_left;
          held_color  = in_pen_color;
          greyed_mode = in_greyed;
          row_odd     = in_top[0];
        end else if (rows_left != 0 && clip_width != 0 && column < clip_width) begin
          bits = in_data_byte;
          if (greyed_mode) bits = bits & (row_odd ? MASK_ODD : MASK_EVEN);
          span = clip_width - column;
          if (span > BYTE_BITS) span = BYTE_BITS;
          last_k = -1;
          for (int k = 0; k < span; k++)
            if ((bits & (BIT_LEFT >> k)) != 0) last_k = k;
          for (int k = 0; k < span; k++) begin
            if ((bits & (BIT_LEFT >> k)) != 0) begin
              want.addr  = ADDR_BITS'(int'(row_base) + int'(left_edge) + int'(column) + k);
              want.color = held_color;
              want.last  = (k == last_k);
              pixel_writes_due.push_back(want);
            end
          end
          column = GLYPH_BITS'(int'(column) + span);
          if (column >= clip_width) begin
            column    = '0;
            rows_left = rows_left - 1'b1;
            row_base  = row_base + ADDR_BITS'(buf_width);
            row_odd   = ~row_odd;
          end
        end
      end
    end
    writes_due = pixel_writes_due.size();
  end

endmodule

// ===== sim/bitmap_glyph_blitter_tb.sv =====
`timescale 1ns / 1ps
// Top of the bitmap_glyph_blitter regression: drives glyph beats, register writes
// and result pops with random idling, and gives the verdict from bgb_checker.
// Depends on bgb_pkg, bitmap_glyph_blitter and bgb_checker.
module bitmap_glyph_blitter_tb;
  import bgb_pkg::*;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      push = 1'b0;
  logic                      full;
  logic                      in_cmd = CMD_BEGIN;
  logic [GLYPH_BITS-1:0]     in_glyph_width = '0;
  logic [GLYPH_BITS-1:0]     in_glyph_height = '0;
  logic [COORD_BITS_DEF-1:0] in_top = '0;
  logic [COORD_BITS_DEF-1:0] in_left = '0;
  logic [COLOR_BITS-1:0]     in_pen_color = '0;
  logic                      in_greyed = 1'b0;
  logic [BYTE_BITS-1:0]      in_data_byte = '0;
  logic                      empty;
  logic                      pop = 1'b0;
  logic [ADDR_BITS-1:0]      out_pixel_address;
  logic [COLOR_BITS-1:0]     out_pixel_color;
  logic                      out_last;
  logic                      cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0]   cfg_index = REG_BUF_WIDTH;
  logic [COORD_BITS_DEF-1:0] cfg_data = '0;
  int                        mismatches;
  int                        writes_due;

  bit in_idle_on = 1'b1;
  bit out_idle_on = 1'b1;
  int width_now = BUF_WIDTH_RST;
  int height_now = BUF_HEIGHT_RST;
  int painted_beats = 0;

  bitmap_glyph_blitter dut (.*);
  bgb_checker check (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #1000000;
    $display("bitmap_glyph_blitter regression: fail");
    $finish;
  end

  function automatic int pick_wait(bit on);
    return on ? $urandom_range(0, 12) : 0;
  endfunction

  initial begin : result_side
    int stall;
    @(posedge rst_n);
    forever begin
      stall = pick_wait(out_idle_on);
      @(negedge clk);
      if (stall > 0) begin
        pop <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
      while (empty) @(posedge clk);
    end
  end

  task automatic send_beat(cmd_t cmd, int gw, int gh, int tp, int lf, int color, bit grey,
                           int data);
    int gap;
    gap = pick_wait(in_idle_on);
    @(negedge clk);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    push            <= 1'b1;
    in_cmd          <= cmd;
    in_glyph_width  <= GLYPH_BITS'(gw);
    in_glyph_height <= GLYPH_BITS'(gh);
    in_top          <= COORD_BITS_DEF'(tp);
    in_left         <= COORD_BITS_DEF'(lf);
    in_pen_color    <= COLOR_BITS'(color);
    in_greyed       <= grey;
    in_data_byte    <= BYTE_BITS'(data);
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  task automatic send_byte(int data);
    send_beat(CMD_DATA, $urandom_range(0, 255), $urandom_range(0, 255),
              $urandom_range(0, 4095), $urandom_range(0, 4095), $urandom_range(0, 255),
              $urandom_range(0, 1), data);
  endtask

  // drop push, drain every due write, then idle while the pipe clears
  task automatic settle();
    @(negedge clk);
    push <= 1'b0;
    while (writes_due != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, int val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= COORD_BITS_DEF'(val);
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_BUF_WIDTH) width_now = val;
    else height_now = val;
  endtask

  task automatic paint_glyph(int gw, int gh, int tp, int lf, bit grey, int skew);
    int cols, rows, total;
    cols = (width_now > lf) ? width_now - lf : 0;
    if (gw < cols) cols = gw;
    rows = (height_now > tp) ? height_now - tp : 0;
    if (gh < rows) rows = gh;
    total = ((cols + 7) / 8) * rows + skew;
    send_beat(CMD_BEGIN, gw, gh, tp, lf, $urandom_range(0, 255), grey,
              $urandom_range(0, 255));
    if (cols > 0 && rows > 0) painted_beats += 1 + ((total > 0) ? total : 0);
    for (int i = 0; i < total; i++) send_byte($urandom_range(0, 255));
  endtask

  function automatic int pick_extent();
    case ($urandom_range(0, 7))
      0: return 0;
      1: return 1;
      2: return 4095;
      3: return $urandom_range(8, 64);
      4: return $urandom_range(100, 400);
      default: return $urandom_range(1, 4095);
    endcase
  endfunction

  initial begin : stimulus
    int gw, gh, tp, lf, skew;
    bit wide;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // partial byte at the end of each row
    send_beat(CMD_BEGIN, 10, 2, 3, 5, 255, 1'b0, 0);
    send_byte(8'hFF);
    send_byte(8'hFF);
    send_byte(8'h81);
    send_byte(8'h40);
    // greyed glyph on an odd then an even row
    send_beat(CMD_BEGIN, 8, 2, 1, 0, 0, 1'b1, 255);
    send_byte(8'hFF);
    send_byte(8'hFF);
    // clip at the right and bottom edges; an all-clear byte paints nothing
    send_beat(CMD_BEGIN, 255, 255, 199, 310, 8'hA5, 1'b0, 0);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'hFF);
    // no room at all
    send_beat(CMD_BEGIN, 0, 0, 4095, 4095, 0, 1'b1, 0);
    send_byte(8'hFF);
    // restart a glyph in progress
    send_beat(CMD_BEGIN, 16, 1, 0, 0, 8'h5A, 1'b0, 0);
    send_byte(8'hFF);
    send_beat(CMD_BEGIN, 8, 1, 0, 0, 8'h3C, 1'b0, 0);
    send_byte(8'h01);
    settle();
    // change the row stride in the middle of a glyph
    send_beat(CMD_BEGIN, 8, 3, 10, 20, 8'h77, 1'b1, 0);
    send_byte(8'hF0);
    settle();
    write_reg(REG_BUF_WIDTH, 4095);
    send_byte(8'h0F);
    settle();
    // zero width clips everything away
    write_reg(REG_BUF_WIDTH, 0);
    send_beat(CMD_BEGIN, 8, 1, 0, 0, 8'h11, 1'b0, 0);
    send_byte(8'hFF);
    settle();
    write_reg(REG_BUF_WIDTH, 1);
    write_reg(REG_BUF_HEIGHT, 1);
    send_beat(CMD_BEGIN, 255, 255, 0, 0, 255, 1'b0, 0);
    send_byte(8'h80);
    send_byte(8'hFF);

    while (painted_beats < 180) begin
      settle();
      if ($urandom_range(0, 2) != 0) write_reg(REG_BUF_WIDTH, pick_extent());
      if ($urandom_range(0, 2) != 0) write_reg(REG_BUF_HEIGHT, pick_extent());
      in_idle_on  = ($urandom_range(0, 3) != 0);
      out_idle_on = ($urandom_range(0, 3) != 0);
      repeat ($urandom_range(1, 4)) begin
        case ($urandom_range(0, 9))
          0: begin
            send_beat(CMD_BEGIN, $urandom_range(0, 255), $urandom_range(0, 255),
                      $urandom_range(0, 4095), $urandom_range(0, 4095),
                      $urandom_range(0, 255), $urandom_range(0, 1), $urandom_range(0, 255));
            repeat ($urandom_range(0, 3)) send_byte($urandom_range(0, 255));
          end
          1: repeat ($urandom_range(1, 3)) send_byte($urandom_range(0, 255));
          default: begin
            wide = ($urandom_range(0, 9) == 0);
            gw   = wide ? $urandom_range(0, 255) : $urandom_range(1, 24);
            gh   = wide ? 1 : $urandom_range(1, 5);
            tp   = (height_now > 0) ? $urandom_range(0, height_now - 1)
                                    : $urandom_range(0, 4095);
            lf   = (width_now > 0) ? $urandom_range(0, width_now - 1)
                                   : $urandom_range(0, 4095);
            skew = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 3) - 2 : 0;
            paint_glyph(gw, gh, tp, lf, $urandom_range(0, 1), skew);
          end
        endcase
      end
    end

    settle();
    repeat (20) @(negedge clk);
    if (mismatches == 0 && writes_due == 0) begin
      $display("bitmap_glyph_blitter regression: pass");
    end else begin
      $display("bitmap_glyph_blitter regression: fail");
    end
    $finish;
  end

endmodule
